// File: hdl/wpsp_pkg.sv
// Shared constants and types for the WAV PCM stream parser.
// No dependencies; imported by wav_pcm_stream_parser_unit.
`timescale 1ns / 1ps
`default_nettype none

package wpsp_pkg;

	// Header limits.
	localparam int unsigned MAX_CHANNELS     = 8;
	localparam int unsigned HEADER_MIN_BYTES = 44;

	// Four-character tags, first file byte in the high byte.
	localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
	localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
	localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
	localparam logic [31:0] TAG_DATA = 32'h6461_7461;

	// Parser phase codes.
	localparam logic [2:0] PH_RIFF       = 3'd0;
	localparam logic [2:0] PH_CHUNK      = 3'd1;
	localparam logic [2:0] PH_WAVE       = 3'd2;
	localparam logic [2:0] PH_FMT_SCAN   = 3'd3;
	localparam logic [2:0] PH_FMT_FIELDS = 3'd4;
	localparam logic [2:0] PH_DATA_SCAN  = 3'd5;
	localparam logic [2:0] PH_DATA_SIZE  = 3'd6;
	localparam logic [2:0] PH_SAMPLES    = 3'd7;

	// Byte positions inside the fmt chunk after its tag (counted after the byte).
	localparam logic [4:0] FI_WORD    = 5'd4;
	localparam logic [4:0] FI_FORMAT  = 5'd6;
	localparam logic [4:0] FI_CHANS   = 5'd8;
	localparam logic [4:0] FI_RATE    = 5'd12;
	localparam logic [4:0] FI_AVGRATE = 5'd16;
	localparam logic [4:0] FI_ALIGN   = 5'd18;
	localparam logic [4:0] FI_BITS    = 5'd20;

	// Result kinds.
	localparam logic [1:0] KIND_SAMPLE = 2'd0;
	localparam logic [1:0] KIND_HEADER = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	// Error codes.
	localparam logic [2:0] ERR_TOO_SMALL    = 3'd0;
	localparam logic [2:0] ERR_NO_RIFF      = 3'd1;
	localparam logic [2:0] ERR_NOT_WAVE     = 3'd2;
	localparam logic [2:0] ERR_NO_FMT       = 3'd3;
	localparam logic [2:0] ERR_NOT_PCM      = 3'd4;
	localparam logic [2:0] ERR_NO_DATA      = 3'd5;
	localparam logic [2:0] ERR_BAD_BITS     = 3'd6;
	localparam logic [2:0] ERR_BAD_CHANNELS = 3'd7;

	localparam logic [15:0] FMT_PCM = 16'd1;
	localparam logic [15:0] BITS_8  = 16'd8;
	localparam logic [15:0] BITS_16 = 16'd16;

	localparam int unsigned RES_BITS  = 138;
	localparam int unsigned TDATA_W   = 144;

	// One result item.
	typedef struct packed {
		logic [15:0] bits_per_sample;
		logic [15:0] block_align;
		logic [31:0] byte_rate;
		logic [31:0] sample_rate;
		logic [15:0] channels;
		logic [2:0]  error_code;
		logic        frame_end;
		logic [5:0]  channel;
		logic [15:0] sample;
	} res_t;

endpackage

`default_nettype wire

// File: hdl/wav_pcm_stream_parser_unit.sv
// WAV PCM stream parser: header checker and sample extractor, top level.
// Depends on wpsp_pkg for tags, phase codes, result kinds and error codes.
`timescale 1ns / 1ps
`default_nettype none

// The parser takes a WAV file one byte per transfer on the slave stream and
// sustains one byte per clock cycle while the master side accepts results.
// Each byte is first captured in an input register. Once the output register
// is free, the parser state is updated from that register by a short piece of
// logic (a byte shift, a tag compare, a 32-bit count compare), and any result
// lands in the output register at the end of that cycle, so a result passes
// through the input register and the output register before its transfer. The
// output register frees itself in the cycle that its transfer completes, so
// back-to-back bytes flow without bubbles; while the master side stalls with a
// result pending, the input register holds one more byte and then backpressure
// reaches the slave side. Results carry a kind on tuser: an audio sample, the
// header once it has been checked, or an error. Errors are sticky: after one
// error no further result appears until reset. Bytes beyond file_bytes are
// swallowed silently. The file length must be written on the configuration
// channel before the first byte of a file, while the block is idle; a write
// takes effect on the next byte.
module wav_pcm_stream_parser_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Configuration: file length in bytes.
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [31:0]                   cfg_data,
	// Input bytes. tdata: data_byte[7:0].
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire logic [7:0]                    s_axis_tdata,
	// Results. tdata from bit 0: sample[15:0], channel[21:16], frame_end[22],
	// error_code[25:23], channels[41:26], sample_rate[73:42],
	// byte_rate[105:74], block_align[121:106], bits_per_sample[137:122],
	// zero fill[143:138]. tuser: kind[1:0].
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	output logic [wpsp_pkg::TDATA_W-1:0]       m_axis_tdata,
	output logic [1:0]                         m_axis_tuser
);
	import wpsp_pkg::*;

	// Input register.
	logic        in_valid_s1;
	logic [7:0]  in_byte_s1;

	// Parser state.
	logic [31:0] file_bytes_q;
	logic [2:0]  phase_q,      phase_d;
	logic [31:0] byte_count_q, byte_count_d;
	logic [31:0] word_q,       word_d;
	logic [4:0]  field_q,      field_d;
	logic [15:0] chan_cnt_q,   chan_cnt_d;
	logic [31:0] rate_q,       rate_d;
	logic [31:0] avg_rate_q,   avg_rate_d;
	logic [15:0] align_q,      align_d;
	logic [15:0] bits_q,       bits_d;
	logic [5:0]  cur_chan_q,   cur_chan_d;
	logic [8:0]  held_q,       held_d;
	logic        error_q,      error_d;

	// Output register.
	logic        out_valid_q;
	logic [1:0]  kind_q;
	res_t        res_q;

	// Result of the byte being processed.
	logic        res_valid;
	logic [1:0]  res_kind;
	res_t        res;

	logic        out_free;
	logic        proc;
	logic        last_byte;
	logic        stop;
	logic        do_err;
	logic [2:0]  err_code;
	logic        do_sample;
	logic [15:0] sample_val;
	logic        frame_last;
	logic [15:0] le16_w;
	logic [31:0] le32_w;

	assign cfg_ready     = 1'b1;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign proc          = in_valid_s1 && out_free;
	assign s_axis_tready = !in_valid_s1 || out_free;

	// Little-endian views of the shift word after the current byte is in.
	assign le16_w = {word_d[7:0], word_d[15:8]};
	assign le32_w = {word_d[7:0], word_d[15:8], word_d[23:16], word_d[31:24]};

	// A sample closes its frame when the next channel index reaches the count.
	assign frame_last = ({10'd0, cur_chan_q} + 16'd1) == chan_cnt_q;

	always_comb begin
		phase_d      = phase_q;
		byte_count_d = byte_count_q;
		word_d       = word_q;
		field_d      = field_q;
		chan_cnt_d   = chan_cnt_q;
		rate_d       = rate_q;
		avg_rate_d   = avg_rate_q;
		align_d      = align_q;
		bits_d       = bits_q;
		cur_chan_d   = cur_chan_q;
		held_d       = held_q;
		last_byte    = 1'b0;
		stop         = 1'b0;
		do_err       = 1'b0;
		err_code     = ERR_TOO_SMALL;
		do_sample    = 1'b0;
		sample_val   = 16'd0;
		res_valid    = 1'b0;
		res_kind     = KIND_SAMPLE;
		res          = '0;

		if (proc && !error_q) begin
			if (byte_count_q == 32'd0 &&
			    file_bytes_q <= HEADER_MIN_BYTES[31:0]) begin
				do_err = 1'b1;
			end else if (byte_count_q < file_bytes_q) begin
				byte_count_d = byte_count_q + 32'd1;
				word_d       = {word_q[23:0], in_byte_s1};
				field_d      = field_q + 5'd1;
				last_byte    = (byte_count_d == file_bytes_q);

				case (phase_q)
					PH_RIFF: begin
						if (field_d == FI_WORD) begin
							if (word_d != TAG_RIFF) begin
								do_err   = 1'b1;
								err_code = ERR_NO_RIFF;
								stop     = 1'b1;
							end else begin
								phase_d = PH_CHUNK;
								field_d = 5'd0;
							end
						end
					end
					PH_CHUNK: begin
						if (field_d == FI_WORD) begin
							phase_d = PH_WAVE;
							field_d = 5'd0;
						end
					end
					PH_WAVE: begin
						if (field_d == FI_WORD) begin
							if (word_d != TAG_WAVE) begin
								do_err   = 1'b1;
								err_code = ERR_NOT_WAVE;
								stop     = 1'b1;
							end else begin
								phase_d = PH_FMT_SCAN;
								field_d = 5'd0;
							end
						end
					end
					PH_FMT_SCAN: begin
						if (field_d == FI_WORD) begin
							field_d = 5'd0;
							if (word_d == TAG_FMT) begin
								phase_d = PH_FMT_FIELDS;
							end
						end
					end
					PH_FMT_FIELDS: begin
						case (field_d)
							FI_FORMAT: begin
								if (le16_w != FMT_PCM) begin
									do_err   = 1'b1;
									err_code = ERR_NOT_PCM;
									stop     = 1'b1;
								end
							end
							FI_CHANS:   chan_cnt_d = le16_w;
							FI_RATE:    rate_d     = le32_w;
							FI_AVGRATE: avg_rate_d = le32_w;
							FI_ALIGN:   align_d    = le16_w;
							FI_BITS: begin
								bits_d  = le16_w;
								phase_d = PH_DATA_SCAN;
								field_d = 5'd0;
							end
							default: ;
						endcase
					end
					PH_DATA_SCAN: begin
						if (field_d == FI_WORD) begin
							field_d = 5'd0;
							if (word_d == TAG_DATA) begin
								phase_d = PH_DATA_SIZE;
							end
						end
					end
					PH_DATA_SIZE: begin
						if (field_d == FI_WORD) begin
							stop = 1'b1;
							if (chan_cnt_q == 16'd0 ||
							    chan_cnt_q > MAX_CHANNELS[15:0]) begin
								do_err   = 1'b1;
								err_code = ERR_BAD_CHANNELS;
							end else if (bits_q != BITS_8 && bits_q != BITS_16) begin
								do_err   = 1'b1;
								err_code = ERR_BAD_BITS;
							end else begin
								phase_d                  = PH_SAMPLES;
								field_d                  = 5'd0;
								cur_chan_d               = 6'd0;
								held_d                   = 9'd0;
								res_valid                = 1'b1;
								res_kind                 = KIND_HEADER;
								res.channels             = chan_cnt_q;
								res.sample_rate          = rate_q;
								res.byte_rate            = avg_rate_q;
								res.block_align          = align_q;
								res.bits_per_sample      = bits_q;
							end
						end
					end
					default: begin
						// Sample data. The end of the file is no error here.
						stop    = 1'b1;
						field_d = 5'd0;
						if (bits_q == BITS_8) begin
							// 257*x - 32768 is the byte doubled with the sign bit flipped.
							do_sample  = 1'b1;
							sample_val = {~in_byte_s1[7], in_byte_s1[6:0], in_byte_s1};
						end else if (held_q[8]) begin
							do_sample  = 1'b1;
							sample_val = {in_byte_s1, held_q[7:0]};
							held_d     = 9'd0;
						end else begin
							held_d = {1'b1, in_byte_s1};
						end
					end
				endcase

				// The file ended before the header was complete.
				if (!stop && last_byte) begin
					do_err = 1'b1;
					if (phase_d == PH_RIFF || phase_d == PH_CHUNK || phase_d == PH_WAVE) begin
						err_code = ERR_TOO_SMALL;
					end else if (phase_d == PH_FMT_SCAN) begin
						err_code = ERR_NO_FMT;
					end else begin
						err_code = ERR_NO_DATA;
					end
				end
			end
		end

		if (do_sample) begin
			res_valid     = 1'b1;
			res_kind      = KIND_SAMPLE;
			res.sample    = sample_val;
			res.channel   = cur_chan_q;
			res.frame_end = frame_last;
			cur_chan_d    = frame_last ? 6'd0 : cur_chan_q + 6'd1;
		end

		if (do_err) begin
			res_valid      = 1'b1;
			res_kind       = KIND_ERROR;
			res            = '0;
			res.error_code = err_code;
		end

		error_d = error_q || do_err;
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_bytes_q <= 32'd0;
		end else if (cfg_valid && cfg_ready) begin
			file_bytes_q <= cfg_data;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			in_byte_s1 <= s_axis_tdata;
		end
	end

	// Parser state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_RIFF;
			byte_count_q <= 32'd0;
			word_q       <= 32'd0;
			field_q      <= 5'd0;
			chan_cnt_q   <= 16'd0;
			rate_q       <= 32'd0;
			avg_rate_q   <= 32'd0;
			align_q      <= 16'd0;
			bits_q       <= 16'd0;
			cur_chan_q   <= 6'd0;
			held_q       <= 9'd0;
			error_q      <= 1'b0;
		end else if (proc) begin
			phase_q      <= phase_d;
			byte_count_q <= byte_count_d;
			word_q       <= word_d;
			field_q      <= field_d;
			chan_cnt_q   <= chan_cnt_d;
			rate_q       <= rate_d;
			avg_rate_q   <= avg_rate_d;
			align_q      <= align_d;
			bits_q       <= bits_d;
			cur_chan_q   <= cur_chan_d;
			held_q       <= held_d;
			error_q      <= error_d;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= proc && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && res_valid) begin
			kind_q <= res_kind;
			res_q  <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = kind_q;
	assign m_axis_tdata  = {{(TDATA_W - RES_BITS){1'b0}}, res_q};

	// Once an error has been taken, the only result left can be that error.
	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		error_q && out_valid_q |-> kind_q == KIND_ERROR)
		else $error("result other than the error pending after an error");

	// Samples appear only once the header has been accepted.
	a_sample_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q == KIND_SAMPLE |-> phase_q == PH_SAMPLES)
		else $error("sample result outside the sample phase");

	// A frame end marks the highest channel index of the frame.
	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q == KIND_SAMPLE && res_q.frame_end
		|-> ({10'd0, res_q.channel} + 16'd1) == chan_cnt_q)
		else $error("frame end on a channel other than the last");

	// The byte counter never runs past the file length without an error.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		proc && !error_q && byte_count_q < file_bytes_q
		|=> byte_count_q <= $past(file_bytes_q))
		else $error("byte count passed the file length");

endmodule

`default_nettype wire
